// ===== hdl/hgbp_pkg.sv =====
// hgbp_pkg: types, constants and state codes for the hybrid gshare/bimodal predictor.
// Used by hgbp_ctrl, hgbp_dp, the top level and the port checker.
// No dependencies.
package hgbp_pkg;

    // Table sizes (index widths in bits)
    localparam int GSHARE_MAX_BITS  = 12;
    localparam int BIMODAL_MAX_BITS = 12;
    localparam int CHOOSER_MAX_BITS = 12;
    localparam int GSHARE_DEPTH     = 1 << GSHARE_MAX_BITS;
    localparam int BIMODAL_DEPTH    = 1 << BIMODAL_MAX_BITS;
    localparam int CHOOSER_DEPTH    = 1 << CHOOSER_MAX_BITS;

    // Clear sweep covers the largest table
    localparam int CLR_BITS_GB = (GSHARE_MAX_BITS > BIMODAL_MAX_BITS) ?
                                 GSHARE_MAX_BITS : BIMODAL_MAX_BITS;
    localparam int CLR_BITS    = (CLR_BITS_GB > CHOOSER_MAX_BITS) ?
                                 CLR_BITS_GB : CHOOSER_MAX_BITS;

    localparam int HIST_W  = GSHARE_MAX_BITS;
    localparam int CNT_W   = 3;
    localparam int CHS_W   = 2;
    localparam int TOTAL_W = 32;
    localparam int ADDR_W  = 24;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 4;

    // Counter reset values and limits
    localparam logic [CNT_W-1:0] CNT_INIT  = 3'd4;
    localparam logic [CNT_W-1:0] CNT_MAX   = 3'd7;
    localparam logic [CHS_W-1:0] CHS_INIT  = 2'd1;
    localparam logic [CHS_W-1:0] CHS_MAX   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GSHARE_BITS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIMODAL_BITS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOOSER_BITS = 4'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] CFG_GSHARE_RST  = 4'd12;
    localparam logic [CFG_W-1:0] CFG_HISTORY_RST = 4'd8;
    localparam logic [CFG_W-1:0] CFG_BIMODAL_RST = 4'd12;
    localparam logic [CFG_W-1:0] CFG_CHOOSER_RST = 4'd12;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } in_item_t;

    typedef struct packed {
        logic               predicted_taken;
        logic               mispredicted;
        logic               used_gshare;
        logic [TOTAL_W-1:0] prediction_count;
        logic [TOTAL_W-1:0] mispredict_count;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic update;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
    } dp_status_t;

endpackage

// ===== hdl/hybrid_gshare_bimodal_predictor.sv =====
// Hybrid gshare/bimodal branch predictor, top level.
// Depends on hgbp_pkg, hgbp_ctrl and hgbp_dp.
//
// Each accepted item is one resolved branch; one result item comes back per branch with
// the prediction made before training, the mispredict flag, the component used and the
// running totals. An item goes through index capture, a registered table read, and
// training with write back, which waits while the result register is full and stalled;
// the next item is taken once the previous one is written back, while its result may
// still wait in the output register. After reset the block clears all 4096 entries of
// each table and accepts no item meanwhile; configuration writes are taken at any time
// (cfg_ready is always high) and should be made only while the block is idle.
module hybrid_gshare_bimodal_predictor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  hgbp_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output hgbp_pkg::out_item_t              out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hgbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hgbp_pkg::CFG_W-1:0]       cfg_data
);
    import hgbp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    hgbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    hgbp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== hdl/hgbp_ctrl.sv =====
// hgbp_ctrl: sequencer for the predictor (table clear, lookup, update, result slot).
// Depends on hgbp_pkg.
module hgbp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output hgbp_pkg::dp_cmd_t    cmd,
    input  hgbp_pkg::dp_status_t status
);
    import hgbp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Result slot can take a new item when empty or being drained now
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_en = 1'b1;
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_READ:   ;
            ST_UPDATE: cmd.update = out_free;
            default:   ;
        endcase
        out_valid_next = cmd.update || (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/hgbp_dp.sv =====
// hgbp_dp: predictor datapath: config registers, counter tables, history, totals,
// result register. Depends on hgbp_pkg; driven by hgbp_ctrl commands.
module hgbp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hgbp_pkg::dp_cmd_t                  cmd,
    output hgbp_pkg::dp_status_t               status,
    input  hgbp_pkg::in_item_t                 in_item,
    output hgbp_pkg::out_item_t                out_item,
    input  logic                              cfg_we,
    input  logic [hgbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hgbp_pkg::CFG_W-1:0]         cfg_data
);
    import hgbp_pkg::*;

    // Configuration
    logic [CFG_W-1:0] cfg_g_reg;
    logic [CFG_W-1:0] cfg_h_reg;
    logic [CFG_W-1:0] cfg_b_reg;
    logic [CFG_W-1:0] cfg_c_reg;

    // Control state
    logic [HIST_W-1:0]   ghist_reg;
    logic [HIST_W-1:0]   ghist_next;
    logic [TOTAL_W-1:0]  branch_total_reg;
    logic [TOTAL_W-1:0]  miss_total_reg;
    logic [CLR_BITS-1:0] clr_cnt_reg;

    // Item registers
    logic [GSHARE_MAX_BITS-1:0]  gi_reg;
    logic [BIMODAL_MAX_BITS-1:0] bi_reg;
    logic [CHOOSER_MAX_BITS-1:0] ci_reg;
    logic                        taken_reg;
    out_item_t                   out_item_reg;

    // Tables and registered read data
    logic [CNT_W-1:0] g_mem [GSHARE_DEPTH];
    logic [CNT_W-1:0] b_mem [BIMODAL_DEPTH];
    logic [CHS_W-1:0] c_mem [CHOOSER_DEPTH];
    logic [CNT_W-1:0] g_rdata_reg;
    logic [CNT_W-1:0] b_rdata_reg;
    logic [CHS_W-1:0] c_rdata_reg;

    // Effective widths
    logic [4:0] gb;
    logic [4:0] hb;
    logic [4:0] bb;
    logic [4:0] cb;

    logic [HIST_W-1:0]           hist;
    logic [GSHARE_MAX_BITS-1:0]  gi;
    logic [BIMODAL_MAX_BITS-1:0] bi;
    logic [CHOOSER_MAX_BITS-1:0] ci;
    logic [ADDR_W-3:0]           pc;

    logic pg, pb, use_g, ph, miss;
    logic [CNT_W-1:0] trained;
    logic [CHS_W-1:0] chs_new;

    logic                        g_we, b_we, c_we;
    logic [GSHARE_MAX_BITS-1:0]  g_waddr;
    logic [BIMODAL_MAX_BITS-1:0] b_waddr;
    logic [CHOOSER_MAX_BITS-1:0] c_waddr;
    logic [CNT_W-1:0]            g_wdata;
    logic [CNT_W-1:0]            b_wdata;
    logic [CHS_W-1:0]            c_wdata;

    // Mask of the low 'bits' bits
    function automatic logic [31:0] low_mask(input logic [4:0] bits);
        logic [32:0] m;
        m = (33'd1 << bits) - 33'd1;
        return m[31:0];
    endfunction

    // Saturating 3-bit counter step
    function automatic logic [CNT_W-1:0] train3(input logic [CNT_W-1:0] c, input logic t);
        logic [CNT_W-1:0] r;
        r = c;
        if (t)
        begin
            if (c != CNT_MAX) r = c + 3'd1;
        end
        else
        begin
            if (c != '0) r = c - 3'd1;
        end
        return r;
    endfunction

    // Width clamping
    always_comb
    begin
        if (cfg_g_reg == '0)
            gb = 5'd1;
        else if (int'(cfg_g_reg) > GSHARE_MAX_BITS)
            gb = 5'(GSHARE_MAX_BITS);
        else
            gb = 5'(cfg_g_reg);

        if (cfg_h_reg == '0)
            hb = 5'd1;
        else if (5'(cfg_h_reg) > gb)
            hb = gb;
        else
            hb = 5'(cfg_h_reg);

        if (int'(cfg_b_reg) > BIMODAL_MAX_BITS)
            bb = 5'(BIMODAL_MAX_BITS);
        else
            bb = 5'(cfg_b_reg);

        if (int'(cfg_c_reg) > CHOOSER_MAX_BITS)
            cb = 5'(CHOOSER_MAX_BITS);
        else
            cb = 5'(cfg_c_reg);
    end

    // Index formation from the incoming item
    assign pc   = in_item.branch_address[ADDR_W-1:2];
    assign hist = ghist_reg & HIST_W'(low_mask(hb));
    assign gi   = (pc[GSHARE_MAX_BITS-1:0] ^ GSHARE_MAX_BITS'(hist))
                  & GSHARE_MAX_BITS'(low_mask(gb));
    assign bi   = pc[BIMODAL_MAX_BITS-1:0] & BIMODAL_MAX_BITS'(low_mask(bb));
    assign ci   = pc[CHOOSER_MAX_BITS-1:0] & CHOOSER_MAX_BITS'(low_mask(cb));

    // Prediction and training from read data
    assign pg      = (g_rdata_reg >= CNT_INIT);
    assign pb      = (b_rdata_reg >= CNT_INIT);
    assign use_g   = (c_rdata_reg >= 2'd2);
    assign ph      = use_g ? pg : pb;
    assign miss    = (ph != taken_reg);
    assign trained = train3(use_g ? g_rdata_reg : b_rdata_reg, taken_reg);

    // Chooser moves toward the component that alone was right
    always_comb
    begin
        chs_new = c_rdata_reg;
        if (pg == taken_reg && pb != taken_reg)
        begin
            if (c_rdata_reg != CHS_MAX) chs_new = c_rdata_reg + 2'd1;
        end
        else if (pb == taken_reg && pg != taken_reg)
        begin
            if (c_rdata_reg != '0) chs_new = c_rdata_reg - 2'd1;
        end
    end

    // History shifts right, outcome enters at the top of the active length
    assign ghist_next = (hist >> 1) | (HIST_W'(taken_reg) << (hb - 5'd1));

    // Table write ports: clear sweep or item update
    always_comb
    begin
        if (cmd.clear_en)
        begin
            g_we    = 1'b1;
            b_we    = 1'b1;
            c_we    = 1'b1;
            g_waddr = clr_cnt_reg[GSHARE_MAX_BITS-1:0];
            b_waddr = clr_cnt_reg[BIMODAL_MAX_BITS-1:0];
            c_waddr = clr_cnt_reg[CHOOSER_MAX_BITS-1:0];
            g_wdata = CNT_INIT;
            b_wdata = CNT_INIT;
            c_wdata = CHS_INIT;
        end
        else
        begin
            g_we    = cmd.update && use_g;
            b_we    = cmd.update && !use_g;
            c_we    = cmd.update;
            g_waddr = gi_reg;
            b_waddr = bi_reg;
            c_waddr = ci_reg;
            g_wdata = trained;
            b_wdata = trained;
            c_wdata = chs_new;
        end
    end

    assign status.clear_done = (clr_cnt_reg == '1);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_g_reg <= CFG_GSHARE_RST;
            cfg_h_reg <= CFG_HISTORY_RST;
            cfg_b_reg <= CFG_BIMODAL_RST;
            cfg_c_reg <= CFG_CHOOSER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GSHARE_BITS:  cfg_g_reg <= cfg_data;
                CFG_HISTORY_BITS: cfg_h_reg <= cfg_data;
                CFG_BIMODAL_BITS: cfg_b_reg <= cfg_data;
                CFG_CHOOSER_BITS: cfg_c_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // History, totals and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ghist_reg        <= '0;
            branch_total_reg <= '0;
            miss_total_reg   <= '0;
            clr_cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_en)
                clr_cnt_reg <= clr_cnt_reg + CLR_BITS'(1);
            if (cmd.update)
            begin
                ghist_reg        <= ghist_next;
                branch_total_reg <= branch_total_reg + 32'd1;
                miss_total_reg   <= miss_total_reg + TOTAL_W'(miss);
            end
        end
    end

    // Item capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            gi_reg    <= gi;
            bi_reg    <= bi;
            ci_reg    <= ci;
            taken_reg <= in_item.taken;
        end
        if (cmd.update)
        begin
            out_item_reg.predicted_taken  <= ph;
            out_item_reg.mispredicted     <= miss;
            out_item_reg.used_gshare      <= use_g;
            out_item_reg.prediction_count <= branch_total_reg + 32'd1;
            out_item_reg.mispredict_count <= miss_total_reg + TOTAL_W'(miss);
        end
    end

    // Gshare table
    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[g_waddr] <= g_wdata;
        g_rdata_reg <= g_mem[gi_reg];
    end

    // Bimodal table
    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[b_waddr] <= b_wdata;
        b_rdata_reg <= b_mem[bi_reg];
    end

    // Chooser table
    always_ff @(posedge clk)
    begin
        if (c_we)
            c_mem[c_waddr] <= c_wdata;
        c_rdata_reg <= c_mem[ci_reg];
    end

    assign out_item = out_item_reg;

endmodule

// ===== hdl/hgbp_checker.sv =====
// hgbp_checker: port-level checks on the predictor, bound to the top level.
// Depends on hgbp_pkg and hybrid_gshare_bimodal_predictor.
module hgbp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input hgbp_pkg::out_item_t    out_item
);
    import hgbp_pkg::*;

    logic [TOTAL_W-1:0] last_pred_reg;
    logic [TOTAL_W-1:0] last_miss_reg;
    logic               out_take;

    assign out_take = out_valid && !out_stall;

    // Totals of the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pred_reg <= '0;
            last_miss_reg <= '0;
        end
        else if (out_take)
        begin
            last_pred_reg <= out_item.prediction_count;
            last_miss_reg <= out_item.mispredict_count;
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // One item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted item");

    // Each delivered result counts exactly one more branch
    a_pred_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> out_item.prediction_count == last_pred_reg + 32'd1)
        else $error("prediction count skipped or repeated");

    // Miss total moves with the mispredict flag
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> out_item.mispredict_count ==
                     last_miss_reg + TOTAL_W'(out_item.mispredicted))
        else $error("mispredict count inconsistent with flag");

endmodule

bind hybrid_gshare_bimodal_predictor hgbp_checker u_hgbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
